@@ src/srs_pkg.sv @@
// Shared types for the stable record sorter.
// Holds the key and tag types and the per-cell control word.
// No dependencies; used by srs_cell and stable_record_sorter_unit.
package srs_pkg;

    localparam int KeyW = 44;
    localparam int TagW = 16;

    typedef logic [KeyW-1:0] key_t;
    typedef logic [TagW-1:0] tag_t;

    // Control word broadcast from the top level to every cell.
    typedef struct packed {
        logic insert;   // a new word is placed into the chain this cycle
        logic shift;    // every cell takes the contents of the cell below
    } cell_ctrl_t;

endpackage

@@ src/srs_cell.sv @@
// One cell of the sorting chain: holds one record and compares it with the arriving word.
// Depends on srs_pkg for the key, tag and control types.
module srs_cell
(
    input  logic               clk,
    input  srs_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  srs_pkg::key_t      ins_key,
    input  srs_pkg::tag_t      ins_tag,
    input  logic               lt_prev,
    input  srs_pkg::key_t      prev_key,
    input  srs_pkg::tag_t      prev_tag,
    input  srs_pkg::key_t      next_key,
    input  srs_pkg::tag_t      next_tag,
    output logic               lt,
    output srs_pkg::key_t      key,
    output srs_pkg::tag_t      tag
);

    srs_pkg::key_t key_reg;
    srs_pkg::key_t key_next;
    srs_pkg::tag_t tag_reg;
    srs_pkg::tag_t tag_next;

    // The new word belongs at or above this cell when the cell is empty or holds a
    // strictly larger key; equal keys keep the older record above the new one.
    assign lt = !occupied || (ins_key < key_reg);

    // Insertion moves larger records one cell down; draining moves all records up.
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.insert)
        begin
            if (lt_prev)
            begin
                key_next = prev_key;
                tag_next = prev_tag;
            end
            else if (lt)
            begin
                key_next = ins_key;
                tag_next = ins_tag;
            end
        end
        else if (ctrl.shift)
        begin
            key_next = next_key;
            tag_next = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

@@ src/stable_record_sorter_unit.sv @@
// Stable ascending record sorter built from a chain of insertion cells.
// Depends on srs_pkg and srs_cell.
//
// Usage: records arrive as words on the input channel (in_valid / in_stall),
// one per cycle. Each accepted word is placed into its sorted position in the
// same cycle by a row of DEPTH cells that all compare against it at once, so
// loading runs at one word per cycle with no stall. A word with final_record
// set ends the set: from the next cycle the chain drains from its head on the
// output channel (out_valid / out_stall), one word per cycle while the
// receiver does not stall, smallest key first; records with equal keys leave
// in load order. The first result is shown in the cycle after the final word
// is accepted. While draining, in_stall is high; when the receiver stalls,
// the head cell and all others hold. Words beyond DEPTH records are dropped
// and overflow_seen is set on every result of that set; end_of_run marks the
// last one. Reset empties the chain and clears the overflow flag.
module stable_record_sorter_unit
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srs_pkg::key_t       sort_key,
    input  srs_pkg::tag_t       record_tag,
    input  logic                final_record,
    output logic                out_valid,
    input  logic                out_stall,
    output srs_pkg::key_t       sorted_key,
    output srs_pkg::tag_t       sorted_tag,
    output logic                end_of_run,
    output logic                overflow_seen
);

    localparam int CntW = $clog2(DEPTH + 1);

    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic                drain_reg;
    logic                drain_next;
    logic                overflow_reg;
    logic                overflow_next;
    logic                full;
    logic                in_accept;
    logic                out_accept;
    logic                last_out;
    srs_pkg::cell_ctrl_t ctrl;

    srs_pkg::key_t       cell_key [DEPTH];
    srs_pkg::tag_t       cell_tag [DEPTH];
    logic                cell_lt  [DEPTH];

    // Handshake and chain control.
    assign full       = (count_reg == CntW'(DEPTH));
    assign in_stall   = drain_reg;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = drain_reg;
    assign out_accept = out_valid && !out_stall;
    assign last_out   = (count_reg == CntW'(1));
    assign ctrl.insert = in_accept && !full;
    assign ctrl.shift  = out_accept;

    // Fill count, drain mode and overflow flag.
    always_comb
    begin
        count_next    = count_reg;
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (ctrl.shift)
        begin
            count_next = count_reg - CntW'(1);
        end
        if (in_accept && full)
        begin
            overflow_next = 1'b1;
        end
        if (in_accept && final_record)
        begin
            drain_next = 1'b1;
        end
        if (out_accept && last_out)
        begin
            drain_next    = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    // The row of cells; each sees its neighbors above and below.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          occ;
        logic          lt_up;
        srs_pkg::key_t up_key;
        srs_pkg::tag_t up_tag;
        srs_pkg::key_t dn_key;
        srs_pkg::tag_t dn_tag;

        assign occ = (count_reg > CntW'(i));

        if (i == 0)
        begin : g_head
            assign lt_up  = 1'b0;
            assign up_key = sort_key;
            assign up_tag = record_tag;
        end
        else
        begin : g_body
            assign lt_up  = cell_lt[i-1];
            assign up_key = cell_key[i-1];
            assign up_tag = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign dn_key = cell_key[i];
            assign dn_tag = cell_tag[i];
        end
        else
        begin : g_mid
            assign dn_key = cell_key[i+1];
            assign dn_tag = cell_tag[i+1];
        end

        srs_cell u_cell
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .occupied (occ),
            .ins_key  (sort_key),
            .ins_tag  (record_tag),
            .lt_prev  (lt_up),
            .prev_key (up_key),
            .prev_tag (up_tag),
            .next_key (dn_key),
            .next_tag (dn_tag),
            .lt       (cell_lt[i]),
            .key      (cell_key[i]),
            .tag      (cell_tag[i])
        );
    end

    // Results leave from the head of the chain.
    assign sorted_key    = cell_key[0];
    assign sorted_tag    = cell_tag[0];
    assign end_of_run    = last_out;
    assign overflow_seen = overflow_reg;

    // Draining never runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (count_reg != '0))
        else $error("drain mode with an empty chain");

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("fill count beyond capacity");

    // Taking the last result of a set ends the drain.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_out) |=> !out_valid)
        else $error("drain continued after the last result");

    // Successive results of one set are in ascending key order.
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !last_out) |=> (sorted_key >= $past(sorted_key)))
        else $error("results out of order");

endmodule

@@ sim/stable_record_sorter_unit_tb.sv @@
// Self-checking testbench for stable_record_sorter_unit: streams record sets in, predicts
// the stably sorted output of every set and compares it word by word.
// Depends on srs_pkg and stable_record_sorter_unit.
module stable_record_sorter_unit_tb;

    localparam int SORT_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 50;
    localparam srs_pkg::key_t KEY_MAX = '1;

    // Flavors of key content used when building a record set.
    typedef enum int {
        KEY_ANY,
        KEY_PRICE,
        KEY_CODE,
        KEY_TIED,
        KEY_EDGE
    } key_style_t;

    // Receiver behavior, redrawn at random when each stretch ends.
    typedef enum int {
        DRAIN_FREE,
        DRAIN_SPOTTY,
        DRAIN_CHOKED
    } drain_mode_t;

    // One input word waiting to be sent; hold makes the sender wait for an empty pipe.
    typedef struct {
        srs_pkg::key_t key;
        srs_pkg::tag_t tag;
        logic          last;
        bit            hold;
    } in_word_t;

    // One expected output word.
    typedef struct {
        srs_pkg::key_t key;
        srs_pkg::tag_t tag;
        logic          run_end;
        logic          dropped;
    } sorted_word_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    srs_pkg::key_t sort_key = '0;
    srs_pkg::tag_t record_tag = '0;
    logic          final_record = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    srs_pkg::key_t sorted_key;
    srs_pkg::tag_t sorted_tag;
    logic          end_of_run;
    logic          overflow_seen;

    in_word_t     words_to_send[$];
    sorted_word_t due_results[$];

    // Predictor state: the records of the set being loaded.
    srs_pkg::key_t held_key[SORT_DEPTH];
    srs_pkg::tag_t held_tag[SORT_DEPTH];
    int            held_count = 0;
    logic          held_overflow = 1'b0;

    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_phase = 0;
    drain_mode_t  drain_mode = DRAIN_FREE;
    bit           taken;
    in_word_t     next_word;
    sorted_word_t want;

    stable_record_sorter_unit #(
        .DEPTH(SORT_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sort_key(sort_key),
        .record_tag(record_tag),
        .final_record(final_record),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_key(sorted_key),
        .sorted_tag(sorted_tag),
        .end_of_run(end_of_run),
        .overflow_seen(overflow_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t: %s got %0h, wanted %0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic srs_pkg::key_t pick_key(key_style_t style);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case (style)
            KEY_PRICE: return srs_pkg::key_t'(raw % 64'd100_000_000);
            KEY_CODE:  return srs_pkg::key_t'(64'd1_000_000_000_000
                                              + raw % 64'd9_000_000_000_000);
            KEY_TIED:  return srs_pkg::key_t'(raw % 64'd4);
            KEY_EDGE:
            begin
                if (raw[1:0] == 2'd0)
                    return '0;
                else if (raw[1:0] == 2'd1)
                    return KEY_MAX;
                else
                    return KEY_MAX - srs_pkg::key_t'(raw[2]);
            end
            default:   return raw[srs_pkg::KeyW-1:0];
        endcase
    endfunction

    task automatic queue_word(srs_pkg::key_t k, srs_pkg::tag_t t, logic last, bit hold);
        in_word_t w;
        w.key = k;
        w.tag = t;
        w.last = last;
        w.hold = hold;
        words_to_send.push_back(w);
    endtask

    // A set of n records with random tags; only the first may wait for an empty pipe.
    task automatic queue_set(int n, key_style_t style, bit hold);
        for (int i = 0; i < n; i++)
            queue_word(pick_key(style), srs_pkg::tag_t'($urandom_range(0, 65535)),
                       i == n - 1, hold && i == 0);
    endtask

    task automatic queue_random_sets(int until_count);
        while (words_to_send.size() < until_count)
            queue_set($urandom_range(1, 10), key_style_t'($urandom_range(0, 4)),
                      $urandom_range(0, 5) == 0);
    endtask

    // Accepted word: store it or mark the set as overflowed; a final word releases the set.
    task automatic note_word(srs_pkg::key_t k, srs_pkg::tag_t t, logic last);
        srs_pkg::key_t move_key;
        srs_pkg::tag_t move_tag;
        int            j;
        sorted_word_t  rec;
        if (held_count < SORT_DEPTH)
        begin
            held_key[held_count] = k;
            held_tag[held_count] = t;
            held_count++;
        end
        else
        begin
            held_overflow = 1'b1;
        end
        if (last)
        begin
            // Stable insertion sort: a record moves down only past strictly larger keys.
            for (int i = 1; i < held_count; i++)
            begin
                move_key = held_key[i];
                move_tag = held_tag[i];
                j = i;
                while (j > 0 && held_key[j-1] > move_key)
                begin
                    held_key[j] = held_key[j-1];
                    held_tag[j] = held_tag[j-1];
                    j--;
                end
                held_key[j] = move_key;
                held_tag[j] = move_tag;
            end
            for (int i = 0; i < held_count; i++)
            begin
                rec.key = held_key[i];
                rec.tag = held_tag[i];
                rec.run_end = (i == held_count - 1);
                rec.dropped = held_overflow;
                due_results.push_back(rec);
            end
            held_count = 0;
            held_overflow = 1'b0;
        end
    endtask

    // Sender: presents words in bursts separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
                note_word(sort_key, record_tag, final_record);
            if (!in_valid || taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() == 0
                         || (words_to_send[0].hold && due_results.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_word = words_to_send.pop_front();
                    in_valid <= 1'b1;
                    sort_key <= next_word.key;
                    record_tag <= next_word.tag;
                    final_record <= next_word.last;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall behavior switches between free, spotty and choked stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                drain_mode = drain_mode_t'($urandom_range(0, 2));
                stall_phase = $urandom_range(20, 80);
            end
            else
            begin
                stall_phase = stall_phase - 1;
            end
            case (drain_mode)
                DRAIN_FREE:   out_stall <= 1'b0;
                DRAIN_SPOTTY: out_stall <= ($urandom_range(0, 3) == 0);
                default:      out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Output check: every accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch("word with nothing expected, sorted_key", 64'(sorted_key),
                                64'd0);
            end
            else
            begin
                want = due_results.pop_front();
                if (sorted_key !== want.key)
                    report_mismatch("sorted_key", 64'(sorted_key), 64'(want.key));
                if (sorted_tag !== want.tag)
                    report_mismatch("sorted_tag", 64'(sorted_tag), 64'(want.tag));
                if (end_of_run !== want.run_end)
                    report_mismatch("end_of_run", 64'(end_of_run), 64'(want.run_end));
                if (overflow_seen !== want.dropped)
                    report_mismatch("overflow_seen", 64'(overflow_seen), 64'(want.dropped));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        // Single record set at the top key.
        queue_word(KEY_MAX, 16'hFFFF, 1'b1, 1'b0);
        // Extremes of key and tag interleaved, with ties on both ends.
        queue_word(KEY_MAX, 16'hFFFF, 1'b0, 1'b0);
        queue_word('0, 16'h0000, 1'b0, 1'b0);
        queue_word(KEY_MAX, 16'h0002, 1'b0, 1'b0);
        queue_word('0, 16'hFFFE, 1'b1, 1'b0);
        // All keys equal: output must keep load order.
        for (int i = 0; i < 5; i++)
            queue_word(srs_pkg::key_t'(5), srs_pkg::tag_t'(10 + i), i == 4, 1'b0);
        // Strictly descending keys, the worst case for the sort.
        for (int i = 0; i < 6; i++)
            queue_word(srs_pkg::key_t'(6 - i), srs_pkg::tag_t'(20 + i), i == 5, 1'b0);
        // Already ascending keys.
        for (int i = 0; i < 4; i++)
            queue_word(srs_pkg::key_t'(64'h555_5555_5555 + i),
                       srs_pkg::tag_t'(16'hAAAA + i), i == 3, 1'b0);

        // Random sets, one that fills the store exactly and one that overflows it,
        // the final word of the latter landing on a full store.
        queue_random_sets(60);
        queue_set(SORT_DEPTH, KEY_CODE, 1'b1);
        queue_random_sets(135);
        queue_set(SORT_DEPTH + 3, KEY_TIED, 1'b0);
        queue_random_sets(210);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SORT_DEPTH + 16) @(posedge clk);

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
